@@ rtl/lcbm_pkg.sv @@
package lcbm_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] prg_bank_8000;
    logic [7:0] prg_bank_a000;
    logic [7:0] prg_bank_c000;
    logic [7:0] prg_bank_e000;
    logic [5:0] chr_bank_low;
    logic [5:0] chr_bank_high;
    logic       chr_low_is_ram;
    logic       chr_high_is_ram;
    logic       mirror_horizontal;
  } out_item_t;

  localparam logic KIND_CPU = 1'b0;
  localparam logic KIND_PPU = 1'b1;

  localparam logic [15:0] CPU_DEC_MASK   = 16'hE001;
  localparam logic [15:0] CPU_DEC_SELECT = 16'h8000;
  localparam logic [15:0] CPU_DEC_LOAD   = 16'h8001;
  localparam logic [15:0] CPU_DEC_MIRROR = 16'hA000;

  localparam logic [15:0] PPU_WIN_MASK = 16'h1FF0;
  localparam logic [15:0] PPU_WIN_FD   = 16'h1FD0;
  localparam logic [15:0] PPU_WIN_FE   = 16'h1FE0;

  localparam logic [2:0] SEL_CHR_LOW_FIRST   = 3'd0;
  localparam logic [2:0] SEL_CHR_LOW_SECOND  = 3'd1;
  localparam logic [2:0] SEL_CHR_HIGH_FIRST  = 3'd2;
  localparam logic [2:0] SEL_CHR_HIGH_SECOND = 3'd4;
  localparam logic [2:0] SEL_PRG_FIRST       = 3'd6;
  localparam logic [2:0] SEL_PRG_SECOND      = 3'd7;

  localparam logic [8:0] PRG_COUNT_RESET = 9'd32;

endpackage

@@ rtl/lcbm_stream_if.sv @@
interface lcbm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/latched_chr_bank_mapper.sv @@
// Latched CHR bank mapper (MMC3-style PRG/CHR banking with an MMC2-style CHR
// latch). Each input transaction is a CPU register write (kind 0) or a PPU
// pattern fetch address (kind 1) and yields exactly one result transaction
// holding the full mapping after that item. Throughput is one transaction per
// cycle while the result is not stalled; each item passes the input register
// and then the result register, with the bank state updated as an item moves
// between them. While the result is stalled the input register still takes
// one more transaction. cfg_data (8K PRG ROM bank count) must only be written
// while the block is idle; the fixed banks at C000/E000 are count-2 and
// count-1, truncated to 8 bits.
module latched_chr_bank_mapper (
  input  logic                 clk,
  input  logic                 rst_n,
  lcbm_stream_if.sink          in_stream,
  lcbm_stream_if.source        out_stream,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data
);

  lcbm_pkg::in_item_t  in_r;
  lcbm_pkg::out_item_t out_r;
  lcbm_pkg::out_item_t out_nxt;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;
  logic                in_accept;

  logic [8:0] prg_count_r;
  logic [2:0] bank_select_r, bank_select_nxt;
  logic [5:0] chr_low_first_r, chr_low_first_nxt;
  logic [5:0] chr_low_second_r, chr_low_second_nxt;
  logic [5:0] chr_high_first_r, chr_high_first_nxt;
  logic [5:0] chr_high_second_r, chr_high_second_nxt;
  logic [7:0] prg_first_r, prg_first_nxt;
  logic [7:0] prg_second_r, prg_second_nxt;
  logic       fetch_latch_r, fetch_latch_nxt;
  logic       mirror_mode_r, mirror_mode_nxt;

  logic [15:0] cpu_decoded;
  logic [15:0] ppu_window;
  logic [5:0]  chr_value;
  logic [5:0]  low_bank;
  logic [5:0]  high_bank;

  assign advance        = in_valid_r & (~out_valid_r | out_stream.ready);
  assign in_stream.ready = ~in_valid_r | advance;
  assign in_accept      = in_stream.valid & in_stream.ready;

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_r;

  assign cpu_decoded = in_r.address & lcbm_pkg::CPU_DEC_MASK;
  assign ppu_window  = in_r.address & lcbm_pkg::PPU_WIN_MASK;
  assign chr_value   = in_r.data[7:2];

  always_comb begin
    bank_select_nxt     = bank_select_r;
    chr_low_first_nxt   = chr_low_first_r;
    chr_low_second_nxt  = chr_low_second_r;
    chr_high_first_nxt  = chr_high_first_r;
    chr_high_second_nxt = chr_high_second_r;
    prg_first_nxt       = prg_first_r;
    prg_second_nxt      = prg_second_r;
    fetch_latch_nxt     = fetch_latch_r;
    mirror_mode_nxt     = mirror_mode_r;
    if (in_r.kind == lcbm_pkg::KIND_CPU) begin
      if (cpu_decoded == lcbm_pkg::CPU_DEC_SELECT) begin
        bank_select_nxt = in_r.data[2:0];
      end else if (cpu_decoded == lcbm_pkg::CPU_DEC_LOAD) begin
        unique case (bank_select_r)
          lcbm_pkg::SEL_CHR_LOW_FIRST:   chr_low_first_nxt   = chr_value;
          lcbm_pkg::SEL_CHR_LOW_SECOND:  chr_low_second_nxt  = chr_value;
          lcbm_pkg::SEL_CHR_HIGH_FIRST:  chr_high_first_nxt  = chr_value;
          lcbm_pkg::SEL_CHR_HIGH_SECOND: chr_high_second_nxt = chr_value;
          lcbm_pkg::SEL_PRG_FIRST:       prg_first_nxt       = in_r.data;
          lcbm_pkg::SEL_PRG_SECOND:      prg_second_nxt      = in_r.data;
          default: ;
        endcase
      end else if (cpu_decoded == lcbm_pkg::CPU_DEC_MIRROR) begin
        mirror_mode_nxt = in_r.data[0];
      end
    end else begin
      if (ppu_window == lcbm_pkg::PPU_WIN_FD) begin
        fetch_latch_nxt = 1'b0;
      end else if (ppu_window == lcbm_pkg::PPU_WIN_FE) begin
        fetch_latch_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    low_bank  = fetch_latch_nxt ? chr_low_second_nxt : chr_low_first_nxt;
    high_bank = fetch_latch_nxt ? chr_high_second_nxt : chr_high_first_nxt;
    out_nxt.prg_bank_8000     = prg_first_nxt;
    out_nxt.prg_bank_a000     = prg_second_nxt;
    out_nxt.prg_bank_c000     = prg_count_r[7:0] - 8'd2;
    out_nxt.prg_bank_e000     = prg_count_r[7:0] - 8'd1;
    out_nxt.chr_bank_low      = low_bank;
    out_nxt.chr_bank_high     = high_bank;
    out_nxt.chr_low_is_ram    = (low_bank == 6'd0);
    out_nxt.chr_high_is_ram   = (high_bank == 6'd0);
    out_nxt.mirror_horizontal = mirror_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      prg_count_r       <= lcbm_pkg::PRG_COUNT_RESET;
      bank_select_r     <= 3'd0;
      chr_low_first_r   <= 6'd0;
      chr_low_second_r  <= 6'd0;
      chr_high_first_r  <= 6'd1;
      chr_high_second_r <= 6'd1;
      prg_first_r       <= 8'd0;
      prg_second_r      <= 8'd1;
      fetch_latch_r     <= 1'b0;
      mirror_mode_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        prg_count_r <= cfg_data;
      end
      in_valid_r  <= in_accept | (in_valid_r & ~advance);
      out_valid_r <= advance | (out_valid_r & ~out_stream.ready);
      if (advance) begin
        bank_select_r     <= bank_select_nxt;
        chr_low_first_r   <= chr_low_first_nxt;
        chr_low_second_r  <= chr_low_second_nxt;
        chr_high_first_r  <= chr_high_first_nxt;
        chr_high_second_r <= chr_high_second_nxt;
        prg_first_r       <= prg_first_nxt;
        prg_second_r      <= prg_second_nxt;
        fetch_latch_r     <= fetch_latch_nxt;
        mirror_mode_r     <= mirror_mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_stream.payload;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule
